@@ rtl/core/recm_pkg.sv @@
`timescale 1ns / 1ps
package recm_pkg;

  localparam int IDX_W    = 10;
  localparam int CNT_W    = 8;
  localparam int POS_W    = 24;
  localparam int CHAN_W   = 8;
  localparam int WEIGHT_W = 17;
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int DEF_INDEX_BITS = 10;
  localparam int DEF_COUNT_BITS = 8;

  localparam int SQRT_STAGES = ROOT_W;
  localparam int DIV_STAGES  = WEIGHT_W;
  localparam int TAIL        = SQRT_STAGES + 1 + DIV_STAGES;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [CHAN_W-1:0]   SAT_MAX = 8'd255;

  localparam logic [22:0] RST_MAX_RADIUS   = 23'd65536;
  localparam logic [16:0] RST_ATTENUATION  = 17'd65536;
  localparam logic [23:0] RST_COLOR_A      = {8'd217, 8'd102, 8'd0};
  localparam logic [23:0] RST_COLOR_B      = {8'd89, 8'd204, 8'd204};
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;

  typedef enum logic [2:0] {
    REG_MAX_RADIUS   = 3'd0,
    REG_ATTENUATION  = 3'd1,
    REG_COLOR_A      = 3'd2,
    REG_COLOR_B      = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [IDX_W-1:0]        column;
    logic [IDX_W-1:0]        row;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [CNT_W-1:0]        reflections;
  } ray_t;

  typedef struct packed {
    logic [IDX_W-1:0]  pixel_column;
    logic [IDX_W-1:0]  pixel_row;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

endpackage

@@ rtl/core/ray_exit_color_map.sv @@
`timescale 1ns / 1ps
// An accepted ray request passes registers s0, s1 and s2, the 32-stage square root,
// register s3, the 17-stage divider, then the sa and pixel output registers.
// Throughput is one request per cycle; a stalled pixel freezes the whole pipeline.
// Reset is synchronous and active high; it clears the valid bits and loads the
// configuration registers with their default values.
module ray_exit_color_map #(
  parameter int INDEX_BITS = recm_pkg::DEF_INDEX_BITS,
  parameter int COUNT_BITS = recm_pkg::DEF_COUNT_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ray_valid,
  output logic                        ray_stall,
  input  recm_pkg::ray_t              ray,
  output logic                        pixel_valid,
  input  logic                        pixel_stall,
  output recm_pkg::pixel_t            pixel,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [recm_pkg::ADDR_W-1:0] paddr,
  input  logic [recm_pkg::DATA_W-1:0] pwdata,
  output logic [recm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import recm_pkg::*;

  localparam int VLEN = TAIL + 5;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic [22:0] max_radius;
  logic [16:0] attenuation;
  logic [23:0] color_a;
  logic [23:0] color_b;
  logic [10:0] image_height;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_radius   <= RST_MAX_RADIUS;
      attenuation  <= RST_ATTENUATION;
      color_a      <= RST_COLOR_A;
      color_b      <= RST_COLOR_B;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAX_RADIUS:   max_radius   <= pwdata[22:0];
        REG_ATTENUATION:  attenuation  <= pwdata[16:0];
        REG_COLOR_A:      color_a      <= pwdata[23:0];
        REG_COLOR_B:      color_b      <= pwdata[23:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_RADIUS:   prdata = DATA_W'(max_radius);
      REG_ATTENUATION:  prdata = DATA_W'(attenuation);
      REG_COLOR_A:      prdata = DATA_W'(color_a);
      REG_COLOR_B:      prdata = DATA_W'(color_b);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  logic en;
  logic [VLEN-1:0] vld;

  assign en          = !(pixel_valid && pixel_stall);
  assign ray_stall   = !en;
  assign pixel_valid = vld[VLEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLEN-2:0], ray_valid};
    end
  end

  ray_t s0_ray;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ray <= ray;
    end
  end

  logic [POS_W-1:0] xr;
  logic [POS_W-1:0] yr;
  logic [POS_W-1:0] zr;
  logic [POS_W-1:0] ax;
  logic [POS_W-1:0] ay;
  logic [POS_W-1:0] uz;
  logic [10:0]      row_diff;
  logic [45:0]      r2_c;

  assign xr       = s0_ray.pos_x;
  assign yr       = s0_ray.pos_y;
  assign zr       = s0_ray.pos_z;
  assign ax       = xr[POS_W-1] ? (~xr + 24'd1) : xr;
  assign ay       = yr[POS_W-1] ? (~yr + 24'd1) : yr;
  assign uz       = zr[POS_W-1] ? (~zr + 24'd1) : zr;
  assign row_diff = image_height - 11'd1 - {1'b0, s0_ray.row};
  assign r2_c     = max_radius * max_radius;

  logic [47:0]             s1_ax2;
  logic [47:0]             s1_ay2;
  logic [47:0]             s1_u2;
  logic [45:0]             s1_r2;
  logic                    s1_ge;
  logic                    s1_zxy;
  logic [POS_W-1:0]        s1_x;
  logic [COUNT_BITS-1:0]   s1_n;
  logic [WEIGHT_W-1:0]     s1_att;
  logic [IDX_W-1:0]        s1_col;
  logic [IDX_W-1:0]        s1_row;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax2 <= ax * ax;
      s1_ay2 <= ay * ay;
      s1_u2  <= uz * uz;
      s1_r2  <= r2_c;
      s1_ge  <= (max_radius == 23'd0) || (uz >= {1'b0, max_radius});
      s1_zxy <= (ax == '0) && (ay == '0);
      s1_x   <= xr;
      s1_n   <= COUNT_BITS'(s0_ray.reflections);
      s1_att <= (attenuation > ONE_Q16) ? ONE_Q16 : attenuation;
      s1_col <= s0_ray.column & IDX_MASK;
      s1_row <= row_diff[IDX_W-1:0] & IDX_MASK;
    end
  end

  logic [RAD_W-1:0]      s2_rad;
  logic [45:0]           s2_wnum;
  logic [45:0]           s2_wden;
  logic                  s2_zxy;
  logic [POS_W-1:0]      s2_x;
  logic [COUNT_BITS-1:0] s2_n;
  logic [WEIGHT_W-1:0]   s2_att;
  logic [IDX_W-1:0]      s2_col;
  logic [IDX_W-1:0]      s2_row;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad  <= {s1_ax2 + s1_ay2, 16'h0000};
      s2_wnum <= s1_ge ? 46'd0 : (s1_r2 - s1_u2[45:0]);
      s2_wden <= s1_ge ? 46'd1 : s1_r2;
      s2_zxy  <= s1_zxy;
      s2_x    <= s1_x;
      s2_n    <= s1_n;
      s2_att  <= s1_att;
      s2_col  <= s1_col;
      s2_row  <= s1_row;
    end
  end

  logic [ROOT_W-1:0] h_root;
  logic [POS_W:0]    xd;

  recm_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s2_rad),
    .root (h_root)
  );

  recm_delay #(.W(POS_W + 1), .DEPTH(SQRT_STAGES)) u_x_delay (
    .clk (clk),
    .en  (en),
    .d   ({s2_zxy, s2_x}),
    .q   (xd)
  );

  logic signed [33:0] hx;
  logic [32:0]        s3_num;
  logic [32:0]        s3_den;

  assign hx = $signed({2'b00, h_root}) + $signed({{2{xd[POS_W-1]}}, xd[POS_W-1:0], 8'h00});

  always_ff @(posedge clk) begin
    if (en) begin
      if (xd[POS_W]) begin
        s3_num <= 33'd1;
        s3_den <= 33'd1;
      end else begin
        s3_num <= hx[33] ? 33'd0 : hx[32:0];
        s3_den <= {h_root, 1'b0};
      end
    end
  end

  logic [WEIGHT_W-1:0] w1_q;
  logic [WEIGHT_W-1:0] w2_raw;
  logic [WEIGHT_W-1:0] w2_d;
  logic [WEIGHT_W-1:0] pow_raw;
  logic [WEIGHT_W-1:0] pow_d;
  logic [2*IDX_W-1:0]  side_d;

  recm_div #(.W(33)) u_div_azimuth (
    .clk (clk),
    .en  (en),
    .num (s3_num),
    .den (s3_den),
    .quo (w1_q)
  );

  recm_div #(.W(46)) u_div_height (
    .clk (clk),
    .en  (en),
    .num (s2_wnum),
    .den (s2_wden),
    .quo (w2_raw)
  );

  recm_delay #(.W(WEIGHT_W), .DEPTH(TAIL - DIV_STAGES)) u_w2_delay (
    .clk (clk),
    .en  (en),
    .d   (w2_raw),
    .q   (w2_d)
  );

  recm_pow #(.COUNT_BITS(COUNT_BITS)) u_pow (
    .clk  (clk),
    .en   (en),
    .base (s2_att),
    .n    (s2_n),
    .p    (pow_raw)
  );

  recm_delay #(.W(WEIGHT_W), .DEPTH(TAIL - COUNT_BITS)) u_pow_delay (
    .clk (clk),
    .en  (en),
    .d   (pow_raw),
    .q   (pow_d)
  );

  recm_delay #(.W(2 * IDX_W), .DEPTH(TAIL)) u_side_delay (
    .clk (clk),
    .en  (en),
    .d   ({s2_col, s2_row}),
    .q   (side_d)
  );

  logic [25:0]         mix_r_c;
  logic [25:0]         mix_g_c;
  logic [25:0]         mix_b_c;
  logic [25:0]         sa_mix_r;
  logic [25:0]         sa_mix_g;
  logic [25:0]         sa_mix_b;
  logic [WEIGHT_W-1:0] sa_pow;
  logic [2*IDX_W-1:0]  sa_side;

  assign mix_r_c = w1_q * color_a[23:16] + w2_d * color_b[23:16];
  assign mix_g_c = w1_q * color_a[15:8] + w2_d * color_b[15:8];
  assign mix_b_c = w1_q * color_a[7:0] + w2_d * color_b[7:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sa_mix_r <= mix_r_c;
      sa_mix_g <= mix_g_c;
      sa_mix_b <= mix_b_c;
      sa_pow   <= pow_d;
      sa_side  <= side_d;
    end
  end

  function automatic logic [CHAN_W-1:0] sat_chan(input logic [42:0] prod);
    logic [10:0] v;
    v = prod[42:32];
    return (v[10:8] != 3'd0) ? SAT_MAX : v[7:0];
  endfunction

  logic [42:0] prod_r;
  logic [42:0] prod_g;
  logic [42:0] prod_b;

  assign prod_r = sa_mix_r * sa_pow;
  assign prod_g = sa_mix_g * sa_pow;
  assign prod_b = sa_mix_b * sa_pow;

  always_ff @(posedge clk) begin
    if (en) begin
      pixel.pixel_column <= sa_side[2*IDX_W-1:IDX_W];
      pixel.pixel_row    <= sa_side[IDX_W-1:0];
      pixel.red          <= sat_chan(prod_r);
      pixel.green        <= sat_chan(prod_g);
      pixel.blue         <= sat_chan(prod_b);
    end
  end

  assert property (@(posedge clk) disable iff (rst) vld[TAIL+2] |-> (w1_q <= ONE_Q16))
    else $error("azimuth weight above one");

  assert property (@(posedge clk) disable iff (rst) vld[TAIL+2] |-> (w2_d <= ONE_Q16))
    else $error("height weight above one");

  assert property (@(posedge clk) disable iff (rst) vld[TAIL+2] |-> (pow_d <= ONE_Q16))
    else $error("attenuation power above one");

endmodule

@@ rtl/core/recm_delay.sv @@
`timescale 1ns / 1ps
module recm_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] line [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];
endmodule

@@ rtl/core/recm_sqrt.sv @@
`timescale 1ns / 1ps
module recm_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [recm_pkg::RAD_W-1:0] rad,
  output logic [recm_pkg::ROOT_W-1:0] root
);
  import recm_pkg::*;

  logic [RAD_W-1:0]  rad_q  [0:ROOT_W];
  logic [ROOT_W+1:0] rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] root_q [0:ROOT_W];

  assign rad_q[0]  = rad;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    logic [RAD_W-1:0]  rad_r;
    logic [ROOT_W+1:0] rem_r;
    logic [ROOT_W-1:0] root_r;

    assign cur   = {rem_q[k], rad_q[k][RAD_W-1 -: 2]};
    assign trial = {2'b00, root_q[k], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r <= rad_q[k] << 2;
        if (cur >= trial) begin
          rem_r  <= (ROOT_W+2)'(cur - trial);
          root_r <= {root_q[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= cur[ROOT_W+1:0];
          root_r <= {root_q[k][ROOT_W-2:0], 1'b0};
        end
      end
    end

    assign rad_q[k+1]  = rad_r;
    assign rem_q[k+1]  = rem_r;
    assign root_q[k+1] = root_r;
  end

  assign root = root_q[ROOT_W];
endmodule

@@ rtl/core/recm_div.sv @@
`timescale 1ns / 1ps
module recm_div #(
  parameter int W = 33
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [W-1:0]                  num,
  input  logic [W-1:0]                  den,
  output logic [recm_pkg::WEIGHT_W-1:0] quo
);
  import recm_pkg::*;

  logic [W-1:0]        rem_q [0:WEIGHT_W];
  logic [W-1:0]        den_q [0:WEIGHT_W];
  logic [WEIGHT_W-1:0] quo_q [0:WEIGHT_W];

  assign rem_q[0] = num;
  assign den_q[0] = den;
  assign quo_q[0] = '0;

  for (genvar j = 0; j < WEIGHT_W; j++) begin : g_stage
    logic [W:0]          cur;
    logic [W-1:0]        rem_r;
    logic [W-1:0]        den_r;
    logic [WEIGHT_W-1:0] quo_r;

    if (j == 0) begin : g_first
      assign cur = {1'b0, rem_q[j]};
    end else begin : g_rest
      assign cur = {rem_q[j], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r <= den_q[j];
        if (cur >= {1'b0, den_q[j]}) begin
          rem_r <= W'(cur - {1'b0, den_q[j]});
          quo_r <= {quo_q[j][WEIGHT_W-2:0], 1'b1};
        end else begin
          rem_r <= cur[W-1:0];
          quo_r <= {quo_q[j][WEIGHT_W-2:0], 1'b0};
        end
      end
    end

    assign rem_q[j+1] = rem_r;
    assign den_q[j+1] = den_r;
    assign quo_q[j+1] = quo_r;
  end

  assign quo = quo_q[WEIGHT_W];
endmodule

@@ rtl/core/recm_pow.sv @@
`timescale 1ns / 1ps
module recm_pow #(
  parameter int COUNT_BITS = recm_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [recm_pkg::WEIGHT_W-1:0] base,
  input  logic [COUNT_BITS-1:0]         n,
  output logic [recm_pkg::WEIGHT_W-1:0] p
);
  import recm_pkg::*;

  logic [WEIGHT_W-1:0]   p_q [0:COUNT_BITS];
  logic [WEIGHT_W-1:0]   b_q [0:COUNT_BITS];
  logic [COUNT_BITS-1:0] n_q [0:COUNT_BITS];

  assign p_q[0] = ONE_Q16;
  assign b_q[0] = base;
  assign n_q[0] = n;

  for (genvar i = 0; i < COUNT_BITS; i++) begin : g_stage
    logic [2*WEIGHT_W-1:0] pb;
    logic [2*WEIGHT_W-1:0] bb;
    logic [WEIGHT_W-1:0]   p_r;
    logic [WEIGHT_W-1:0]   b_r;
    logic [COUNT_BITS-1:0] n_r;

    assign pb = p_q[i] * b_q[i];
    assign bb = b_q[i] * b_q[i];

    always_ff @(posedge clk) begin
      if (en) begin
        p_r <= n_q[i][0] ? pb[WEIGHT_W+15:16] : p_q[i];
        b_r <= bb[WEIGHT_W+15:16];
        n_r <= n_q[i] >> 1;
      end
    end

    assign p_q[i+1] = p_r;
    assign b_q[i+1] = b_r;
    assign n_q[i+1] = n_r;
  end

  assign p = p_q[COUNT_BITS];
endmodule
